/* design/lobm_pkg.sv */
`timescale 1ns / 1ps
package lobm_pkg;

	localparam int BOOK_DEPTH = 16;
	localparam int IDX_W = $clog2(BOOK_DEPTH);
	localparam int CNT_W = $clog2(BOOK_DEPTH + 1);
	localparam int RES_W = $clog2(2 * BOOK_DEPTH + 2);

	localparam logic SIDE_BUY = 1'b0;
	localparam logic SIDE_SELL = 1'b1;
	localparam logic KIND_TRADE = 1'b0;
	localparam logic KIND_DROP = 1'b1;

	typedef struct packed {
		logic [15:0] trader;
		logic [31:0] qty;
		logic [31:0] price;
	} entry_t;

	typedef struct packed {
		logic [31:0] qty;
		logic [31:0] price;
	} agg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MRD,
		ST_MCHK,
		ST_RRD,
		ST_RCHK,
		ST_AFL,
		ST_CRD,
		ST_CWR,
		ST_PRD,
		ST_PCHK,
		ST_SRD,
		ST_SWR,
		ST_INS,
		ST_EBEG,
		ST_ERD,
		ST_EOUT
	} state_t;

endpackage

/* design/limit_order_book_matcher.sv */
`timescale 1ns / 1ps
// Price-time priority limit order matcher. Each transfer on the s_ side is one order; it is
// matched against the opposite book, any remainder rests on its own side (or, if that book is
// full, is reported in a drop record), and the merged trade records (resting parties newest
// first, then the aggressor, then a book-full drop record) leave on the m_ side with tlast on
// the final one. Orders are processed one at a time, step by step: each crossed entry is read
// and checked, each record within a same-price merge group is compared, entries are moved up
// after filled entries are removed, entries are passed or shifted on the insert, and each record
// is sent. Each book and record memory has a single read port with a registered read.
module limit_order_book_matcher import lobm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // trader_id[15:0], quantity[47:16], price[79:48]
	input  logic [0:0]  s_tuser,   // side[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // party_trader[15:0], traded_quantity[47:16], trade_price[79:48]
	output logic [1:0]  m_tuser,   // record_kind[0], party_side[1]
	output logic        m_tlast
);

	state_t state_q, state_d;

	logic [15:0]      ord_trader_q;
	logic             ord_side_q;
	logic [31:0]      ord_price_q;
	logic [31:0]      rem_q;
	logic [CNT_W-1:0] idx_q, m_q, nr_q, na_q, grp_start_q, srch_q, pos_q;
	logic [CNT_W-1:0] sell_cnt_q, buy_cnt_q;
	logic [31:0]      grp_price_q, fill_q, fill_price_q;
	logic [15:0]      fill_trader_q;
	logic             agg_valid_q;
	logic [31:0]      agg_price_q, agg_qty_q;
	logic             dropped_q;
	logic [RES_W-1:0] emit_q;
	logic             out_valid_q;
	logic [79:0]      out_data_q;
	logic [1:0]       out_user_q;
	logic             out_last_q;

	logic [$bits(entry_t)-1:0] sell_rdata, buy_rdata, rest_rdata;
	logic [$bits(agg_t)-1:0]   agg_rdata;
	entry_t sell_rd, buy_rd, opp_rd, own_rd, rest_rd;
	agg_t   agg_rd;

	logic             opp_re, opp_we, own_re, own_we, rest_re, rest_we, agg_re, agg_we;
	logic [IDX_W-1:0] opp_raddr, opp_waddr, own_raddr, own_waddr;
	logic [IDX_W-1:0] rest_raddr, rest_waddr, agg_raddr, agg_waddr;
	entry_t           opp_wdata, own_wdata, rest_wdata;
	agg_t             agg_wdata;

	logic             sell_re, sell_we, buy_re, buy_we;
	logic [IDX_W-1:0] sell_raddr, sell_waddr, buy_raddr, buy_waddr;
	entry_t           sell_wdata, buy_wdata;

	logic [CNT_W-1:0] opp_cnt, own_cnt;
	logic             is_buy, crosses, ahead, agg_hit, grp_new, ent_empty, comp_done;
	logic             out_free, rest_hit, s_acc;
	logic [31:0]      fill;
	logic [CNT_W:0]   comp_src;
	logic [RES_W-1:0] total, emit_nx, rest_ridx, agg_ridx;

	assign sell_rd = entry_t'(sell_rdata);
	assign buy_rd  = entry_t'(buy_rdata);
	assign rest_rd = entry_t'(rest_rdata);
	assign agg_rd  = agg_t'(agg_rdata);

	assign is_buy  = (ord_side_q == SIDE_BUY);
	assign opp_rd  = is_buy ? sell_rd : buy_rd;
	assign own_rd  = is_buy ? buy_rd : sell_rd;
	assign opp_cnt = is_buy ? sell_cnt_q : buy_cnt_q;
	assign own_cnt = is_buy ? buy_cnt_q : sell_cnt_q;

	assign crosses   = is_buy ? (opp_rd.price <= ord_price_q) : (opp_rd.price >= ord_price_q);
	assign ahead     = is_buy ? (own_rd.price >= ord_price_q) : (own_rd.price <= ord_price_q);
	assign fill      = (rem_q < opp_rd.qty) ? rem_q : opp_rd.qty;
	assign ent_empty = (opp_rd.qty == fill);
	assign agg_hit   = agg_valid_q && (agg_price_q == opp_rd.price);
	assign grp_new   = (nr_q == '0) || (grp_price_q != opp_rd.price);
	assign rest_hit  = (rest_rd.trader == fill_trader_q);
	assign comp_src  = {1'b0, idx_q} + {1'b0, m_q};
	assign comp_done = (m_q == '0) || (comp_src == {1'b0, opp_cnt});
	assign total     = RES_W'(nr_q) + RES_W'(na_q) + RES_W'(dropped_q);
	assign emit_nx   = emit_q + RES_W'(1);
	assign rest_ridx = RES_W'(nr_q) - emit_q - RES_W'(1);
	assign agg_ridx  = emit_q - RES_W'(nr_q);
	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;

	always_comb begin
		state_d    = state_q;
		opp_re     = 1'b0;
		opp_we     = 1'b0;
		opp_raddr  = idx_q[IDX_W-1:0];
		opp_waddr  = idx_q[IDX_W-1:0];
		opp_wdata  = opp_rd;
		own_re     = 1'b0;
		own_we     = 1'b0;
		own_raddr  = idx_q[IDX_W-1:0];
		own_waddr  = idx_q[IDX_W-1:0];
		own_wdata  = own_rd;
		rest_re    = 1'b0;
		rest_we    = 1'b0;
		rest_raddr = srch_q[IDX_W-1:0];
		rest_waddr = nr_q[IDX_W-1:0];
		rest_wdata = '{trader: fill_trader_q, qty: fill_q, price: fill_price_q};
		agg_re     = 1'b0;
		agg_we     = 1'b0;
		agg_raddr  = agg_ridx[IDX_W-1:0];
		agg_waddr  = na_q[IDX_W-1:0];
		agg_wdata  = '{qty: agg_qty_q, price: agg_price_q};
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc && s_tdata[47:16] != '0) begin
					state_d = ST_MRD;
				end
			end
			ST_MRD: begin
				if (idx_q == opp_cnt || rem_q == '0) begin
					state_d = ST_AFL;
				end else begin
					opp_re  = 1'b1;
					state_d = ST_MCHK;
				end
			end
			ST_MCHK: begin
				if (!crosses) begin
					state_d = ST_AFL;
				end else begin
					opp_we        = 1'b1;
					opp_wdata.qty = opp_rd.qty - fill;
					agg_we        = agg_valid_q && !agg_hit;
					if (grp_new) begin
						rest_we    = 1'b1;
						rest_wdata = '{trader: opp_rd.trader, qty: fill, price: opp_rd.price};
						state_d    = ST_MRD;
					end else begin
						state_d = ST_RRD;
					end
				end
			end
			ST_RRD: begin
				if (srch_q == nr_q) begin
					rest_we = 1'b1;
					state_d = ST_MRD;
				end else begin
					rest_re = 1'b1;
					state_d = ST_RCHK;
				end
			end
			ST_RCHK: begin
				if (rest_hit) begin
					rest_we        = 1'b1;
					rest_waddr     = srch_q[IDX_W-1:0];
					rest_wdata     = rest_rd;
					rest_wdata.qty = rest_rd.qty + fill_q;
					state_d        = ST_MRD;
				end else begin
					state_d = ST_RRD;
				end
			end
			ST_AFL: begin
				agg_we  = agg_valid_q;
				state_d = ST_CRD;
			end
			ST_CRD: begin
				if (comp_done) begin
					if (rem_q == '0 || own_cnt == CNT_W'(BOOK_DEPTH)) begin
						state_d = ST_EBEG;
					end else begin
						state_d = ST_PRD;
					end
				end else begin
					opp_re    = 1'b1;
					opp_raddr = comp_src[IDX_W-1:0];
					state_d   = ST_CWR;
				end
			end
			ST_CWR: begin
				opp_we  = 1'b1;
				state_d = ST_CRD;
			end
			ST_PRD: begin
				if (idx_q == own_cnt) begin
					state_d = ST_SRD;
				end else begin
					own_re  = 1'b1;
					state_d = ST_PCHK;
				end
			end
			ST_PCHK: begin
				state_d = ahead ? ST_PRD : ST_SRD;
			end
			ST_SRD: begin
				if (idx_q == pos_q) begin
					state_d = ST_INS;
				end else begin
					own_re    = 1'b1;
					own_raddr = IDX_W'(idx_q - CNT_W'(1));
					state_d   = ST_SWR;
				end
			end
			ST_SWR: begin
				own_we  = 1'b1;
				state_d = ST_SRD;
			end
			ST_INS: begin
				own_we    = 1'b1;
				own_waddr = pos_q[IDX_W-1:0];
				own_wdata = '{trader: ord_trader_q, qty: rem_q, price: ord_price_q};
				state_d   = ST_EBEG;
			end
			ST_EBEG: begin
				state_d = (total == '0) ? ST_IDLE : ST_ERD;
			end
			ST_ERD: begin
				rest_re    = (emit_q < RES_W'(nr_q));
				rest_raddr = rest_ridx[IDX_W-1:0];
				agg_re     = !rest_re;
				state_d    = ST_EOUT;
			end
			ST_EOUT: begin
				if (out_free) begin
					state_d = (emit_nx == total) ? ST_IDLE : ST_ERD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		sell_re    = is_buy ? opp_re : own_re;
		sell_we    = is_buy ? opp_we : own_we;
		sell_raddr = is_buy ? opp_raddr : own_raddr;
		sell_waddr = is_buy ? opp_waddr : own_waddr;
		sell_wdata = is_buy ? opp_wdata : own_wdata;
		buy_re     = is_buy ? own_re : opp_re;
		buy_we     = is_buy ? own_we : opp_we;
		buy_raddr  = is_buy ? own_raddr : opp_raddr;
		buy_waddr  = is_buy ? own_waddr : opp_waddr;
		buy_wdata  = is_buy ? own_wdata : opp_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sell_cnt_q  <= '0;
			buy_cnt_q   <= '0;
			idx_q       <= '0;
			m_q         <= '0;
			nr_q        <= '0;
			na_q        <= '0;
			srch_q      <= '0;
			pos_q       <= '0;
			grp_start_q <= '0;
			agg_valid_q <= 1'b0;
			dropped_q   <= 1'b0;
			emit_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EOUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						idx_q       <= '0;
						m_q         <= '0;
						nr_q        <= '0;
						na_q        <= '0;
						agg_valid_q <= 1'b0;
						dropped_q   <= 1'b0;
					end
				end
				ST_MCHK: begin
					if (crosses) begin
						if (ent_empty) begin
							m_q <= m_q + CNT_W'(1);
						end
						if (!agg_hit) begin
							agg_valid_q <= 1'b1;
							if (agg_valid_q) begin
								na_q <= na_q + CNT_W'(1);
							end
						end
						if (grp_new) begin
							grp_start_q <= nr_q;
							nr_q        <= nr_q + CNT_W'(1);
							idx_q       <= idx_q + CNT_W'(1);
						end else begin
							srch_q <= grp_start_q;
						end
					end
				end
				ST_RRD: begin
					if (srch_q == nr_q) begin
						nr_q  <= nr_q + CNT_W'(1);
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				ST_RCHK: begin
					if (rest_hit) begin
						idx_q <= idx_q + CNT_W'(1);
					end else begin
						srch_q <= srch_q + CNT_W'(1);
					end
				end
				ST_AFL: begin
					if (agg_valid_q) begin
						na_q <= na_q + CNT_W'(1);
					end
					idx_q <= '0;
				end
				ST_CRD: begin
					if (comp_done) begin
						if (is_buy) begin
							sell_cnt_q <= sell_cnt_q - m_q;
						end else begin
							buy_cnt_q <= buy_cnt_q - m_q;
						end
						dropped_q <= (rem_q != '0) && (own_cnt == CNT_W'(BOOK_DEPTH));
						idx_q     <= '0;
					end
				end
				ST_CWR: begin
					idx_q <= idx_q + CNT_W'(1);
				end
				ST_PRD: begin
					if (idx_q == own_cnt) begin
						pos_q <= idx_q;
						idx_q <= own_cnt;
					end
				end
				ST_PCHK: begin
					if (ahead) begin
						idx_q <= idx_q + CNT_W'(1);
					end else begin
						pos_q <= idx_q;
						idx_q <= own_cnt;
					end
				end
				ST_SWR: begin
					idx_q <= idx_q - CNT_W'(1);
				end
				ST_INS: begin
					if (is_buy) begin
						buy_cnt_q <= buy_cnt_q + CNT_W'(1);
					end else begin
						sell_cnt_q <= sell_cnt_q + CNT_W'(1);
					end
				end
				ST_EBEG: begin
					emit_q <= '0;
				end
				ST_EOUT: begin
					if (out_free) begin
						emit_q <= emit_nx;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					ord_trader_q <= s_tdata[15:0];
					rem_q        <= s_tdata[47:16];
					ord_price_q  <= s_tdata[79:48];
					ord_side_q   <= s_tuser[0];
				end
			end
			ST_MCHK: begin
				if (crosses) begin
					rem_q         <= rem_q - fill;
					fill_q        <= fill;
					fill_price_q  <= opp_rd.price;
					fill_trader_q <= opp_rd.trader;
					if (agg_hit) begin
						agg_qty_q <= agg_qty_q + fill;
					end else begin
						agg_qty_q   <= fill;
						agg_price_q <= opp_rd.price;
					end
					if (grp_new) begin
						grp_price_q <= opp_rd.price;
					end
				end
			end
			ST_EOUT: begin
				if (out_free) begin
					out_last_q <= (emit_nx == total);
					if (emit_q < RES_W'(nr_q)) begin
						out_data_q <= {rest_rd.price, rest_rd.qty, rest_rd.trader};
						out_user_q <= {~ord_side_q, KIND_TRADE};
					end else if (emit_q < RES_W'(nr_q) + RES_W'(na_q)) begin
						out_data_q <= {agg_rd.price, agg_rd.qty, ord_trader_q};
						out_user_q <= {ord_side_q, KIND_TRADE};
					end else begin
						out_data_q <= {ord_price_q, rem_q, ord_trader_q};
						out_user_q <= {ord_side_q, KIND_DROP};
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

	lobm_ram #(.DATA_W($bits(entry_t)), .DEPTH(BOOK_DEPTH)) u_sell_ram (
		.clk   (clk),
		.we    (sell_we),
		.waddr (sell_waddr),
		.wdata (sell_wdata),
		.re    (sell_re),
		.raddr (sell_raddr),
		.rdata (sell_rdata)
	);

	lobm_ram #(.DATA_W($bits(entry_t)), .DEPTH(BOOK_DEPTH)) u_buy_ram (
		.clk   (clk),
		.we    (buy_we),
		.waddr (buy_waddr),
		.wdata (buy_wdata),
		.re    (buy_re),
		.raddr (buy_raddr),
		.rdata (buy_rdata)
	);

	lobm_ram #(.DATA_W($bits(entry_t)), .DEPTH(BOOK_DEPTH)) u_rest_ram (
		.clk   (clk),
		.we    (rest_we),
		.waddr (rest_waddr),
		.wdata (rest_wdata),
		.re    (rest_re),
		.raddr (rest_raddr),
		.rdata (rest_rdata)
	);

	lobm_ram #(.DATA_W($bits(agg_t)), .DEPTH(BOOK_DEPTH)) u_agg_ram (
		.clk   (clk),
		.we    (agg_we),
		.waddr (agg_waddr),
		.wdata (agg_wdata),
		.re    (agg_re),
		.raddr (agg_raddr),
		.rdata (agg_rdata)
	);

endmodule

/* design/lobm_ram.sv */
`timescale 1ns / 1ps
module lobm_ram #(
	parameter int DATA_W = 80,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/lobm_checker.sv */
`timescale 1ns / 1ps
module lobm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [79:0] s_tdata,
	input logic [0:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled output changed");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata[47:16] != 32'd0 |=> !s_tready)
		else $error("order taken while busy");

	a_drop_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast)
		else $error("drop record not last");

	a_qty_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[47:16] != 32'd0)
		else $error("record with zero quantity");

endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (.*);
